// ===== src/sstf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and field constants for the SSTF disk scheduler.
package sstf_pkg;

	localparam int CYL_FIELD_W = 16;
	localparam int INDEX_W     = 5;
	localparam int TOTAL_W     = 21;

	localparam logic [TOTAL_W:0] TOTAL_MAX = {1'b0, {TOTAL_W{1'b1}}};

	typedef struct packed {
		logic [CYL_FIELD_W-1:0] request_cylinder;
		logic                   last_request;
	} req_t;

	typedef struct packed {
		logic [CYL_FIELD_W-1:0] served_cylinder;
		logic [INDEX_W-1:0]     served_index;
		logic [CYL_FIELD_W-1:0] move_distance;
		logic [TOTAL_W-1:0]     total_seek;
		logic                   dropped_requests;
		logic                   last_service;
	} svc_t;

endpackage

// ===== src/sstf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/sstf_disk_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the shortest-seek-time-first disk scheduler.
//
// Usage:
//   req channel (req_valid / req_stall / req): one pending cylinder per beat.
//     Requests are stored in load order; the beat with last_request set closes
//     the batch. Beats past MAX_REQUESTS are dropped and flagged in every
//     result of that batch; a dropped last beat still closes the batch.
//   svc channel (svc_valid / svc_stall / svc): one beat per served request in
//     SSTF order (nearest unserved cylinder to the head, ties to the earliest
//     loaded), last_service set on the final beat of the batch.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): start_head, sampled when
//     the last beat of a batch is taken. cfg_ready is always high.
// Timing:
//   Non-last requests are taken without a stall. Each service scans the N stored
//   entries through the single RAM read port and one distance/compare unit: N
//   reads, the last compare, a scan-done check, then the update.
//   req_stall stays high from the last request until the final result is in
//   the output register. A stalled svc beat holds the sequencer at its update.
// Reset: arst_n clears the sequencer, counters, served flags, head and start_head;
//   store contents are not cleared, only loaded entries are read.
module sstf_disk_scheduler #(
	parameter int MAX_REQUESTS  = 32,
	parameter int CYLINDER_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  sstf_pkg::req_t            req,
	output logic                      svc_valid,
	input  logic                      svc_stall,
	output sstf_pkg::svc_t            svc,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sstf_pkg::CYL_FIELD_W-1:0] cfg_data
);

	// Stored cylinder width: the field never carries more than 16 bits.
	localparam int CW   = (CYLINDER_BITS < sstf_pkg::CYL_FIELD_W) ?
	                      CYLINDER_BITS : sstf_pkg::CYL_FIELD_W;
	localparam int IW   = $clog2(MAX_REQUESTS);
	localparam int CNTW = $clog2(MAX_REQUESTS + 1);
	localparam int TW   = sstf_pkg::TOTAL_W;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SERVE = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           start_head_q;
	logic [CNTW-1:0]         count_q;
	logic                    overflow_q;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CW-1:0]           head_q;
	logic [TW-1:0]           total_q;
	logic [CNTW-1:0]         step_q;
	logic [CNTW-1:0]         scan_k_q;

	// scan pipeline
	logic                    scan_vld_s1;
	logic [IW-1:0]           scan_idx_s1;

	// best candidate of the current scan
	logic                    found_q;
	logic [IW-1:0]           best_idx_q;
	logic [CW-1:0]           best_cyl_q;
	logic [CW-1:0]           best_dist_q;

	logic                    svc_valid_q;
	sstf_pkg::svc_t          svc_q;

	logic                    req_take;
	logic                    store_wr;
	logic [CW-1:0]           rd_cyl;
	logic                    scan_issue;
	logic [CW-1:0]           seek_dist;
	logic                    better;
	logic                    out_free;
	logic                    final_step;
	logic [TW:0]             sum;
	logic [TW-1:0]           total_next;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_LOAD);
	assign req_take  = req_valid && !req_stall;
	assign store_wr  = req_take && (count_q < CNTW'(MAX_REQUESTS));

	assign scan_issue = (state_q == ST_SCAN) && (scan_k_q < count_q);

	sstf_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_REQUESTS)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (CW'(req.request_cylinder)),
		.rd_addr (scan_k_q[IW-1:0]),
		.rd_data (rd_cyl)
	);

	// shared distance / compare unit
	assign seek_dist = (head_q >= rd_cyl) ? (head_q - rd_cyl) : (rd_cyl - head_q);
	assign better    = scan_vld_s1 && !served_q[scan_idx_s1] &&
	                   (!found_q || (seek_dist < best_dist_q));

	assign out_free   = !svc_valid_q || !svc_stall;
	assign final_step = (step_q == count_q - CNTW'(1));
	assign sum        = {1'b0, total_q} + (TW + 1)'(best_dist_q);
	assign total_next = (sum > sstf_pkg::TOTAL_MAX) ? sstf_pkg::TOTAL_MAX[TW-1:0]
	                                                 : sum[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			start_head_q <= '0;
			count_q      <= '0;
			overflow_q   <= 1'b0;
			served_q     <= '0;
			head_q       <= '0;
			total_q      <= '0;
			step_q       <= '0;
			scan_k_q     <= '0;
			scan_vld_s1  <= 1'b0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_cyl_q   <= '0;
			best_dist_q  <= '0;
			svc_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_head_q <= CW'(cfg_data);
			end

			// a new beat loads while the old one leaves or the register is empty
			if ((state_q == ST_SERVE) && out_free) begin
				svc_valid_q <= 1'b1;
			end else if (!svc_stall) begin
				svc_valid_q <= 1'b0;
			end

			scan_vld_s1 <= scan_issue;

			case (state_q)
				ST_LOAD: begin
					if (req_take) begin
						if (store_wr) begin
							count_q <= count_q + CNTW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (req.last_request) begin
							head_q   <= start_head_q;
							total_q  <= '0;
							step_q   <= '0;
							scan_k_q <= '0;
							found_q  <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_k_q <= scan_k_q + CNTW'(1);
					end
					if (better) begin
						found_q     <= 1'b1;
						best_idx_q  <= scan_idx_s1;
						best_cyl_q  <= rd_cyl;
						best_dist_q <= seek_dist;
					end
					// all entries read and the last compare done
					if (!scan_issue && !scan_vld_s1) begin
						state_q <= ST_SERVE;
					end
				end
				ST_SERVE: begin
					if (out_free) begin
						head_q      <= best_cyl_q;
						total_q     <= total_next;
						step_q      <= step_q + CNTW'(1);
						scan_k_q    <= '0;
						found_q     <= 1'b0;
						if (final_step) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							served_q   <= '0;
							state_q    <= ST_LOAD;
						end else begin
							served_q[best_idx_q] <= 1'b1;
							state_q              <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// scan index stage and output payload register
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			scan_idx_s1 <= scan_k_q[IW-1:0];
		end
		if ((state_q == ST_SERVE) && out_free) begin
			svc_q.served_cylinder  <= sstf_pkg::CYL_FIELD_W'(best_cyl_q);
			svc_q.served_index     <= sstf_pkg::INDEX_W'(best_idx_q);
			svc_q.move_distance    <= sstf_pkg::CYL_FIELD_W'(best_dist_q);
			svc_q.total_seek       <= total_next;
			svc_q.dropped_requests <= overflow_q;
			svc_q.last_service     <= final_step;
		end
	end

	assign svc_valid = svc_valid_q;
	assign svc       = svc_q;

endmodule
